// ----- rtl/core/ipdc_pkg.sv -----
// shared types and constants for the dotted-decimal ipv4 parser and classifier
package ipdc_pkg;

  // character codes
  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // largest octet value, at the width of the digit accumulator
  localparam logic [11:0] OctetMax = 12'd255;

  // octets in a complete address
  localparam logic [2:0] OctetCount = 3'd4;

  // upper bounds of the classful ranges on the first byte
  localparam logic [7:0] ClassAMax = 8'd127;
  localparam logic [7:0] ClassBMax = 8'd191;
  localparam logic [7:0] ClassCMax = 8'd223;
  localparam logic [7:0] ClassDMax = 8'd239;

  // address class codes
  localparam logic [2:0] ClassA = 3'd0;
  localparam logic [2:0] ClassB = 3'd1;
  localparam logic [2:0] ClassC = 3'd2;
  localparam logic [2:0] ClassD = 3'd3;
  localparam logic [2:0] ClassE = 3'd4;

  // input transaction
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic        is_valid;
    logic [31:0] address;
    logic [2:0]  address_class;
    logic [1:0]  net_id_octets;
    logic [31:0] network_address;
  } out_item_t;

endpackage

// ----- rtl/core/ipdc_classify.sv -----
// classful classification of a parsed ipv4 address
module ipdc_classify import ipdc_pkg::*; (
  input  logic        ok_i,
  input  logic [31:0] packed_i,
  output out_item_t   result_o
);

  logic [7:0] first_byte;

  assign first_byte = packed_i[31:24];

  // class, net id length and network address from the first byte
  always_comb begin
    result_o = '0;
    if (ok_i) begin
      result_o.is_valid = 1'b1;
      result_o.address  = packed_i;
      if (first_byte inside {[8'd1:ClassAMax]}) begin
        result_o.address_class   = ClassA;
        result_o.net_id_octets   = 2'd1;
        result_o.network_address = {packed_i[31:24], 24'd0};
      end else if (first_byte inside {[ClassAMax + 8'd1:ClassBMax]}) begin
        result_o.address_class   = ClassB;
        result_o.net_id_octets   = 2'd2;
        result_o.network_address = {packed_i[31:16], 16'd0};
      end else if (first_byte inside {[ClassBMax + 8'd1:ClassCMax]}) begin
        result_o.address_class   = ClassC;
        result_o.net_id_octets   = 2'd3;
        result_o.network_address = {packed_i[31:8], 8'd0};
      end else if (first_byte inside {[ClassCMax + 8'd1:ClassDMax]}) begin
        result_o.address_class = ClassD;
      end else begin
        result_o.address_class = ClassE;
      end
    end
  end

endmodule

// ----- rtl/core/ipv4_dotted_parse_classify.sv -----
// top level: dotted-decimal ipv4 line parser with classful result
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (out_item_t)
//
// one character is taken per cycle unless stalled; parse state updates at that edge
// an end-of-line transaction loads the result register and clears the parse state
// the result appears in the cycle after its end-of-line transaction is taken
// in_stall_o is high only while a held result is stalled on the output side
// reset clears the parse state and the output valid flag
module ipv4_dotted_parse_classify import ipdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // parse state
  logic [2:0]  done_q, done_d;
  logic [7:0]  value_q, value_d;
  logic [1:0]  digits_q, digits_d;
  logic        zero_first_q, zero_first_d;
  logic        bad_q, bad_d;
  logic [31:0] packed_q, packed_d;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  out_item_t result;

  logic        accept;
  logic        fin_bad;
  logic [31:0] fin_packed;
  logic [2:0]  fin_done;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] acc;
  logic        line_ok;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // closing the current octet
  assign fin_bad    = (digits_q == 2'd0) || (done_q >= OctetCount);
  assign fin_packed = {packed_q[23:0], value_q};
  assign fin_done   = done_q + 3'd1;

  // digit accumulate: value * 10 + digit
  assign is_digit = (in_data_i.char_code >= CharZero) && (in_data_i.char_code <= CharNine);
  assign digit    = in_data_i.char_code[3:0];
  assign acc      = ({4'd0, value_q} << 3) + ({4'd0, value_q} << 1) + {8'd0, digit};

  // end of line check
  assign line_ok = ~bad_q & ~fin_bad & (fin_done == OctetCount);

  ipdc_classify u_classify (
    .ok_i     (line_ok),
    .packed_i (fin_packed),
    .result_o (result)
  );

  // next parse state
  always_comb begin
    done_d       = done_q;
    value_d      = value_q;
    digits_d     = digits_q;
    zero_first_d = zero_first_q;
    bad_d        = bad_q;
    packed_d     = packed_q;
    if (accept) begin
      if (in_data_i.end_of_line) begin
        done_d       = '0;
        value_d      = '0;
        digits_d     = '0;
        zero_first_d = 1'b0;
        bad_d        = 1'b0;
        packed_d     = '0;
      end else if (!bad_q) begin
        if (in_data_i.char_code == CharDot) begin
          if (fin_bad) begin
            bad_d = 1'b1;
          end else begin
            packed_d = fin_packed;
            done_d   = fin_done;
          end
          value_d      = '0;
          digits_d     = '0;
          zero_first_d = 1'b0;
        end else if (is_digit) begin
          if ((digits_q != 2'd0) && zero_first_q) begin
            // second digit after a leading zero
            bad_d = 1'b1;
          end else begin
            if (digits_q == 2'd0) begin
              zero_first_d = (digit == 4'd0);
            end
            if (acc > OctetMax) begin
              bad_d   = 1'b1;
              value_d = OctetMax[7:0];
            end else begin
              value_d = acc[7:0];
            end
            if (digits_q < 2'd2) begin
              digits_d = digits_q + 2'd1;
            end
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && in_data_i.end_of_line) begin
      out_valid_d = 1'b1;
    end
  end

  // control and parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= '0;
      value_q      <= '0;
      digits_q     <= '0;
      zero_first_q <= 1'b0;
      bad_q        <= 1'b0;
      packed_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      done_q       <= done_d;
      value_q      <= value_d;
      digits_q     <= digits_d;
      zero_first_q <= zero_first_d;
      bad_q        <= bad_d;
      packed_q     <= packed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.end_of_line) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an end-of-line transaction always produces a result next cycle
  a_eol_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_line |=> out_valid_o)
    else $error("end of line gave no result");

  // parse state is clear after an end-of-line transaction
  a_eol_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_line |=> done_q == 3'd0 && !bad_q && digits_q == 2'd0)
    else $error("parse state not cleared after end of line");

  // never more than four completed octets
  a_done_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= OctetCount)
    else $error("octet count out of range");

  // an invalid result carries zero fields
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_valid |->
      out_data_o.address == 32'd0 && out_data_o.network_address == 32'd0 &&
      out_data_o.net_id_octets == 2'd0)
    else $error("invalid result with nonzero fields");

  // class d and e have no net id
  a_de_no_net : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.address_class == ClassD ||
                    out_data_o.address_class == ClassE) |->
      out_data_o.net_id_octets == 2'd0 && out_data_o.network_address == 32'd0)
    else $error("class d or e with a net id");

endmodule
